### rtl/core/oit_pkg.sv
// ----------------------------------------------------------------------------
// oit_pkg
// Shared types and codes for the ordered item table: transaction payloads,
// per-cell compare flags and the cell shift commands.
// ----------------------------------------------------------------------------
package oit_pkg;

   localparam int POS_W       = 7;
   localparam int CAP_W       = 7;
   localparam int FUNC_W      = 3;
   localparam int VAL_FIELD_W = 32;
   localparam int IDX_FIELD_W = 6;
   localparam int CNT_FIELD_W = 7;

   localparam logic [FUNC_W-1:0] FUNC_INSERT_AT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_SORTED = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ERASE         = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_ALL    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ          = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_WRITE         = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_FIND          = 3'd6;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [POS_W-1:0]       position;
      logic [VAL_FIELD_W-1:0] item_value;
   } oit_req_type;

   typedef struct packed {
      logic                   status;
      logic [IDX_FIELD_W-1:0] result_index;
      logic [CNT_FIELD_W-1:0] removed_count;
      logic [VAL_FIELD_W-1:0] read_value;
      logic [CNT_FIELD_W-1:0] entry_count;
      logic                   is_empty;
   } oit_rsp_type;

   // Compare results a cell registers against the pending request
   typedef struct packed {
      logic live;    // slot below the fill count
      logic eq;      // stored value equals request value
      logic le;      // request value not above stored value
      logic at;      // slot index equals request position
      logic ge_pos;  // slot index at or above request position
   } oit_flags_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_LEFT,
      CMD_RIGHT
   } oit_cmd_type;

endpackage

### rtl/core/oit_cell.sv
// ----------------------------------------------------------------------------
// oit_cell
// One slot of the table row: holds a value, takes a neighbor's value or the
// request value on command, and registers its compare flags.
// ----------------------------------------------------------------------------
module oit_cell
   import oit_pkg::*;
#(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int INDEX       = 0
) (
   input  logic                        clock,
   input  oit_cmd_type                 cmd,
   input  logic [VALUE_WIDTH-1:0]      load_val,
   input  logic [VALUE_WIDTH-1:0]      left_val,
   input  logic [VALUE_WIDTH-1:0]      right_val,
   input  logic [POS_W-1:0]            req_pos,
   input  logic [$clog2(DEPTH+1)-1:0]  count,
   output logic [VALUE_WIDTH-1:0]      value,
   output oit_flags_type               flags
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] SLOT = CMP_W'(INDEX);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   oit_flags_type          flags_ff;
   oit_flags_type          flags_in;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       cnt_ext;

   always_comb begin
      pos_ext = CMP_W'(req_pos);
      cnt_ext = CMP_W'(count);
      flags_in.live   = SLOT < cnt_ext;
      flags_in.eq     = value_ff == load_val;
      flags_in.le     = load_val <= value_ff;
      flags_in.at     = SLOT == pos_ext;
      flags_in.ge_pos = SLOT >= pos_ext;
   end

   always_comb begin
      case (cmd)
         CMD_LOAD:  value_in = load_val;
         CMD_LEFT:  value_in = left_val;
         CMD_RIGHT: value_in = right_val;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      flags_ff <= flags_in;
   end

   assign value = value_ff;
   assign flags = flags_ff;

endmodule

### rtl/core/oit_scan.sv
// ----------------------------------------------------------------------------
// oit_scan
// First-hit search across the cell row: inclusive prefix OR of the hit
// vector, any-hit flag and binary index of the first hit.
// ----------------------------------------------------------------------------
module oit_scan
   import oit_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic [DEPTH-1:0]          hit,
   output logic [DEPTH-1:0]          incl,
   output logic                      any,
   output logic [$clog2(DEPTH)-1:0]  first_idx
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [DEPTH-1:0] prefix;
   logic [DEPTH-1:0] first;
   logic [IDX_W-1:0] idx;

   always_comb begin
      prefix = hit;
      // log-depth prefix OR
      for (int s = 1; s < DEPTH; s = s * 2) begin
         prefix = prefix | (prefix << s);
      end
      first = prefix & ~(prefix << 1);
      idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
   end

   assign incl      = prefix;
   assign any       = prefix[DEPTH-1];
   assign first_idx = idx;

endmodule

### rtl/core/ordered_item_table.sv
// ----------------------------------------------------------------------------
// ordered_item_table
// Compact row of values with a fill count: positional and sorted insert,
// erase, remove-all, read, write and find over a shift row of cells.
// ----------------------------------------------------------------------------
// The table is a row of DEPTH cells; each cell holds one entry and can take
// its left neighbor (insert), its right neighbor (delete) or the request
// value. A transaction is accepted only while the block is idle. After
// acceptance the compare state lets every cell register its compare flags
// against the request, and the apply state then scans those flags for the
// first hit, moves the row and loads the response register. Insert, erase,
// read, write and find therefore pass through each state once between
// acceptance and the next acceptance. Remove-all deletes one match per pass,
// each pass being a compare state and an apply state that moves the row, and
// ends with a pass that finds no match. The response register decouples the
// output: a new transaction is accepted while the previous response still
// waits; the apply state holds only when a response is still pending there.
// The capacity register may be written at any time the block is idle and
// takes effect on the next insert. There is no clearing pass; slots at and
// above the fill count are never observed.
// ----------------------------------------------------------------------------
module ordered_item_table
   import oit_pkg::*;
#(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  oit_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output oit_rsp_type        rsp_data,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } state_type;

   state_type               state_ff, state_in;
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        removed_ff, removed_in;
   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   oit_rsp_type             rsp_data_ff, rsp_data_in;

   // cell row
   logic [VALUE_WIDTH-1:0]  cell_val   [DEPTH];
   logic [VALUE_WIDTH-1:0]  left_val   [DEPTH];
   logic [VALUE_WIDTH-1:0]  right_val  [DEPTH];
   oit_flags_type           cell_flags [DEPTH];
   oit_cmd_type             cell_cmd   [DEPTH];

   logic [DEPTH-1:0]        live_vec, eq_vec, le_vec, at_vec, gep_vec;
   logic [DEPTH-1:0]        hit_vec, incl_vec;
   logic                    any_hit;
   logic [IDX_W-1:0]        first_idx;
   logic [VALUE_WIDTH-1:0]  rd_or;

   // request value masked to the stored width
   logic [63:0]             req_val_wide;

   // ------------------------------------------------------------------------
   // Cells
   // ------------------------------------------------------------------------
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_val[g] = value_ff;
      end else begin : g_mid_left
         assign left_val[g] = cell_val[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_val[g] = cell_val[g];
      end else begin : g_mid_right
         assign right_val[g] = cell_val[g+1];
      end

      oit_cell #(
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (g)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd[g]),
         .load_val  (value_ff),
         .left_val  (left_val[g]),
         .right_val (right_val[g]),
         .req_pos   (pos_ff),
         .count     (count_ff),
         .value     (cell_val[g]),
         .flags     (cell_flags[g])
      );
   end

   // Unpack flags and OR together the addressed entry for reads
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         live_vec[i] = cell_flags[i].live;
         eq_vec[i]   = cell_flags[i].eq;
         le_vec[i]   = cell_flags[i].le;
         at_vec[i]   = cell_flags[i].at;
         gep_vec[i]  = cell_flags[i].ge_pos;
         rd_or       = rd_or | (cell_flags[i].at ? cell_val[i] : '0);
      end
   end

   // Hit vector for the first-hit search: sorted insert looks for the first
   // entry not below the value, find and remove look for an equal entry.
   always_comb begin
      case (func_ff)
         FUNC_INSERT_SORTED: hit_vec = le_vec & live_vec;
         FUNC_FIND:          hit_vec = eq_vec & live_vec;
         FUNC_REMOVE_ALL:    hit_vec = eq_vec & live_vec;
         default:            hit_vec = '0;
      endcase
   end

   oit_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .hit       (hit_vec),
      .incl      (incl_vec),
      .any       (any_hit),
      .first_idx (first_idx)
   );

   // ------------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------------
   logic                    full;
   logic                    ins_pos_ok;
   logic                    pos_ok;
   logic                    mode_ins;
   logic                    mode_del;
   logic                    mode_wr;
   logic                    done;
   logic                    st;
   logic [DEPTH-1:0]        geq;
   logic [DEPTH-1:0]        geq_prev;
   logic [DEPTH-1:0]        del_mask;
   logic [31:0]             idx_sel;
   logic [31:0]             rem_sel;
   logic [31:0]             cnt_wide;
   logic [63:0]             rd_wide;
   logic [63:0]             rd_sel;

   always_comb begin
      full       = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || (count_ff >= CNT_MAX);
      ins_pos_ok = CMP_W'(pos_ff) <= CMP_W'(count_ff);
      pos_ok     = CMP_W'(pos_ff) < CMP_W'(count_ff);
      req_val_wide = 64'(req_data.item_value);
      rd_wide    = 64'(rd_or);

      state_in     = state_ff;
      func_in      = func_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      removed_in   = removed_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      mode_ins = 1'b0;
      mode_del = 1'b0;
      mode_wr  = 1'b0;
      done     = 1'b0;
      st       = 1'b1;
      geq      = '0;
      del_mask = '0;
      idx_sel  = '0;
      rem_sel  = '0;
      rd_sel   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in    = req_data.func;
               pos_in     = req_data.position;
               value_in   = req_val_wide[VALUE_WIDTH-1:0];
               removed_in = '0;
               state_in   = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            // hold while the response register is still occupied
            if (!(rsp_valid_ff && !rsp_ready)) begin
               done = 1'b1;
               case (func_ff)
                  FUNC_INSERT_AT: begin
                     if (!full && ins_pos_ok) begin
                        mode_ins = 1'b1;
                        geq      = gep_vec;
                        count_in = count_ff + 1'b1;
                        idx_sel  = 32'(pos_ff);
                        st       = 1'b0;
                     end
                  end
                  FUNC_INSERT_SORTED: begin
                     if (!full) begin
                        mode_ins = 1'b1;
                        // no hit: slot at the fill count opens
                        geq      = incl_vec | ~live_vec;
                        count_in = count_ff + 1'b1;
                        idx_sel  = any_hit ? 32'(first_idx) : 32'(count_ff);
                        st       = 1'b0;
                     end
                  end
                  FUNC_ERASE: begin
                     if (pos_ok) begin
                        mode_del = 1'b1;
                        del_mask = gep_vec;
                        count_in = count_ff - 1'b1;
                        st       = 1'b0;
                     end
                  end
                  FUNC_REMOVE_ALL: begin
                     if (any_hit) begin
                        // drop the first match, then compare again
                        mode_del   = 1'b1;
                        del_mask   = incl_vec;
                        count_in   = count_ff - 1'b1;
                        removed_in = removed_ff + 1'b1;
                        done       = 1'b0;
                        state_in   = ST_COMPARE;
                     end else begin
                        st      = (removed_ff == '0);
                        rem_sel = 32'(removed_ff);
                     end
                  end
                  FUNC_READ: begin
                     if (pos_ok) begin
                        rd_sel = rd_wide;
                        st     = 1'b0;
                     end
                  end
                  FUNC_WRITE: begin
                     if (pos_ok) begin
                        mode_wr = 1'b1;
                        st      = 1'b0;
                     end
                  end
                  FUNC_FIND: begin
                     if (any_hit) begin
                        idx_sel = 32'(first_idx);
                        st      = 1'b0;
                     end
                  end
                  default: begin
                     st = 1'b1;
                  end
               endcase

               if (done) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cnt_wide = 32'(count_in);
      if (done) begin
         rsp_data_in = '{
            status:        st,
            result_index:  idx_sel[IDX_FIELD_W-1:0],
            removed_count: rem_sel[CNT_FIELD_W-1:0],
            read_value:    rd_sel[VAL_FIELD_W-1:0],
            entry_count:   cnt_wide[CNT_FIELD_W-1:0],
            is_empty:      (count_in == '0)
         };
      end

      // Per-cell commands: insert opens the slot at the first geq cell,
      // delete pulls every masked cell from its right neighbor.
      geq_prev = geq << 1;
      for (int i = 0; i < DEPTH; i++) begin
         cell_cmd[i] = CMD_HOLD;
         if (mode_ins) begin
            if (geq_prev[i]) begin
               cell_cmd[i] = CMD_LEFT;
            end else if (geq[i]) begin
               cell_cmd[i] = CMD_LOAD;
            end
         end else if (mode_del) begin
            if (del_mask[i]) begin
               cell_cmd[i] = CMD_RIGHT;
            end
         end else if (mode_wr) begin
            if (at_vec[i]) begin
               cell_cmd[i] = CMD_LOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         removed_ff   <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         removed_ff   <= removed_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
